// ===== rtl/hra_pkg.sv =====
// ----------------------------------------------------------------------------
// hra_pkg
// Shared types and constants of the handle range allocator.
// ----------------------------------------------------------------------------
package hra_pkg;

  localparam int MAX_FREE = 64;
  localparam int IDX_W    = $clog2(MAX_FREE);
  localparam int CNT_W    = $clog2(MAX_FREE + 1);
  localparam int ENT_W    = 32;
  localparam int HND_W    = 16;
  localparam int NEED_W   = 18;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HANDLE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HANDLE = CFG_IDX_W'(1);

  localparam logic [HND_W-1:0] RST_MIN_HANDLE = 16'h0001;
  localparam logic [HND_W-1:0] RST_MAX_HANDLE = 16'hffff;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_CLEAR   = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_LIST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHL,
    S_SHR,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    SEQ_NONE,
    SEQ_SCAN_INIT,
    SEQ_SCAN,
    SEQ_SHL_INIT,
    SEQ_SHL,
    SEQ_SHR_INIT,
    SEQ_SHR
  } seq_op_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_INIT,
    WR_CLEAR,
    WR_SHRINK,
    WR_MERGE_BOTH,
    WR_PREV_EXT,
    WR_NEXT_EXT,
    WR_INSERT
  } wr_op_t;

  typedef enum logic [2:0] {
    CNT_HOLD,
    CNT_INIT,
    CNT_CLEAR,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef struct packed {
    logic    load_in;
    seq_op_t seq;
    wr_op_t  wr;
    cnt_op_t cnt;
    logic    res_load;
    status_t res_status;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  rev;
    logic  scan_hit;
    logic  scan_end;
    logic  shl_done;
    logic  shr_done;
    logic  hit;
    logic  shrink;
    logic  overlap;
    logic  join_prev;
    logic  join_next;
    logic  full;
    logic  bounds_ok;
  } dp_sts_t;

endpackage

// ===== rtl/hra_ram.sv =====
// ----------------------------------------------------------------------------
// hra_ram
// Generic simple dual port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module hra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/hra_dp.sv =====
// ----------------------------------------------------------------------------
// hra_dp
// Datapath: request registers, free list RAM with its walk and shift
// sequencing, entry count, configuration registers and result registers.
// ----------------------------------------------------------------------------
module hra_dp
  import hra_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_sts_t              sts,
  input  logic [1:0]           in_kind,
  input  logic [15:0]          in_include_count,
  input  logic [14:0]          in_char_count,
  input  logic [15:0]          in_desc_count,
  input  logic [15:0]          in_release_start,
  input  logic [15:0]          in_release_end,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_wdata,
  output logic [1:0]           out_status,
  output logic [15:0]          out_range_start,
  output logic [15:0]          out_range_end
);

  kind_t             kind_r, kind_nxt;
  logic [NEED_W-1:0] need_r, need_nxt;
  logic [HND_W-1:0]  rel_lo_r, rel_lo_nxt;
  logic [HND_W-1:0]  rel_hi_r, rel_hi_nxt;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic              hit_r, hit_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [HND_W-1:0]  cur_lo_r, cur_lo_nxt;
  logic [HND_W-1:0]  cur_hi_r, cur_hi_nxt;
  logic [HND_W-1:0]  prev_lo_r, prev_lo_nxt;
  logic [HND_W-1:0]  prev_hi_r, prev_hi_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [HND_W-1:0]  min_r, min_nxt;
  logic [HND_W-1:0]  max_r, max_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [HND_W-1:0]  out_start_r, out_start_nxt;
  logic [HND_W-1:0]  out_end_r, out_end_nxt;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [ENT_W-1:0]  ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [ENT_W-1:0]  ram_rdata;

  logic [HND_W-1:0]  ent_lo, ent_hi;
  logic [HND_W:0]    ent_len;
  logic              match;
  logic [CNT_W-1:0]  rd_m1;
  logic [CNT_W-1:0]  pos_m1;
  logic [NEED_W-1:0] last_ext;
  logic              shrink;

  assign ent_lo   = ram_rdata[31:16];
  assign ent_hi   = ram_rdata[15:0];
  assign ent_len  = {1'b0, ent_hi} - {1'b0, ent_lo} + 17'd1;
  // allocate looks for a long enough range, release for the first range above it
  assign match    = (kind_r == KIND_ALLOC) ? ({1'b0, ent_len} >= need_r)
                                           : (ent_lo > rel_hi_r);
  assign rd_m1    = rd_idx_r - CNT_W'(1);
  assign pos_m1   = pos_r - CNT_W'(1);
  assign last_ext = {2'b00, cur_lo_r} + need_r - NEED_W'(1);
  assign shrink   = last_ext < {2'b00, cur_hi_r};

  assign ram_raddr = (cmd.seq == SEQ_SHR) ? rd_m1[IDX_W-1:0] : rd_idx_r[IDX_W-1:0];

  hra_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_FREE)
  ) u_free_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // status toward the controller
  always_comb begin
    sts.kind      = kind_r;
    sts.rev       = rel_lo_r > rel_hi_r;
    sts.scan_hit  = chk_vld_r && match;
    sts.scan_end  = rd_idx_r >= count_r;
    sts.shl_done  = (rd_idx_r >= count_r) && !chk_vld_r;
    sts.shr_done  = (rd_idx_r <= pos_r) && !chk_vld_r;
    sts.hit       = hit_r;
    sts.shrink    = shrink;
    sts.overlap   = (pos_r != '0) && (prev_hi_r >= rel_lo_r);
    sts.join_prev = (pos_r != '0) && (({1'b0, prev_hi_r} + 17'd1) == {1'b0, rel_lo_r});
    sts.join_next = (pos_r < count_r) && (({1'b0, rel_hi_r} + 17'd1) == {1'b0, cur_lo_r});
    sts.full      = count_r >= CNT_W'(MAX_FREE);
    sts.bounds_ok = min_r <= max_r;
  end

  // RAM write port: shift pipeline first, then single entry updates
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = ram_rdata;
    if ((cmd.seq == SEQ_SHL) && chk_vld_r) begin
      ram_we    = 1'b1;
      ram_waddr = chk_idx_r - IDX_W'(1);
    end else if ((cmd.seq == SEQ_SHR) && chk_vld_r) begin
      ram_we    = 1'b1;
      ram_waddr = chk_idx_r + IDX_W'(1);
    end else begin
      case (cmd.wr)
        WR_NONE: begin
          ram_we = 1'b0;
        end
        WR_INIT: begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = {RST_MIN_HANDLE, RST_MAX_HANDLE};
        end
        WR_CLEAR: begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = {min_r, max_r};
        end
        WR_SHRINK: begin
          ram_we    = 1'b1;
          ram_waddr = pos_r[IDX_W-1:0];
          ram_wdata = {last_ext[HND_W-1:0] + 16'd1, cur_hi_r};
        end
        WR_MERGE_BOTH: begin
          ram_we    = 1'b1;
          ram_waddr = pos_m1[IDX_W-1:0];
          ram_wdata = {prev_lo_r, cur_hi_r};
        end
        WR_PREV_EXT: begin
          ram_we    = 1'b1;
          ram_waddr = pos_m1[IDX_W-1:0];
          ram_wdata = {prev_lo_r, rel_hi_r};
        end
        WR_NEXT_EXT: begin
          ram_we    = 1'b1;
          ram_waddr = pos_r[IDX_W-1:0];
          ram_wdata = {rel_lo_r, cur_hi_r};
        end
        WR_INSERT: begin
          ram_we    = 1'b1;
          ram_waddr = pos_r[IDX_W-1:0];
          ram_wdata = {rel_lo_r, rel_hi_r};
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    kind_nxt       = kind_r;
    need_nxt       = need_r;
    rel_lo_nxt     = rel_lo_r;
    rel_hi_nxt     = rel_hi_r;
    rd_idx_nxt     = rd_idx_r;
    chk_idx_nxt    = chk_idx_r;
    chk_vld_nxt    = chk_vld_r;
    hit_nxt        = hit_r;
    pos_nxt        = pos_r;
    cur_lo_nxt     = cur_lo_r;
    cur_hi_nxt     = cur_hi_r;
    prev_lo_nxt    = prev_lo_r;
    prev_hi_nxt    = prev_hi_r;
    count_nxt      = count_r;
    min_nxt        = min_r;
    max_nxt        = max_r;
    out_status_nxt = out_status_r;
    out_start_nxt  = out_start_r;
    out_end_nxt    = out_end_r;

    if (cmd.load_in) begin
      kind_nxt   = kind_t'(in_kind);
      need_nxt   = NEED_W'(1) + {2'b00, in_include_count}
                 + {2'b00, in_char_count, 1'b0} + {2'b00, in_desc_count};
      rel_lo_nxt = in_release_start;
      rel_hi_nxt = in_release_end;
    end

    case (cmd.seq)
      SEQ_NONE: begin
        chk_vld_nxt = chk_vld_r;
      end
      SEQ_SCAN_INIT: begin
        rd_idx_nxt  = '0;
        chk_vld_nxt = 1'b0;
        hit_nxt     = 1'b0;
      end
      SEQ_SCAN, SEQ_SHL: begin
        if (rd_idx_r < count_r) begin
          chk_idx_nxt = rd_idx_r[IDX_W-1:0];
          chk_vld_nxt = 1'b1;
          rd_idx_nxt  = rd_idx_r + CNT_W'(1);
        end else begin
          chk_vld_nxt = 1'b0;
        end
        if (cmd.seq == SEQ_SCAN) begin
          if (chk_vld_r && match) begin
            hit_nxt    = 1'b1;
            pos_nxt    = CNT_W'(chk_idx_r);
            cur_lo_nxt = ent_lo;
            cur_hi_nxt = ent_hi;
          end else begin
            // remember the last range passed before the match (for release, the last range below the request)
            if (chk_vld_r) begin
              prev_lo_nxt = ent_lo;
              prev_hi_nxt = ent_hi;
            end
            if (rd_idx_r >= count_r) begin
              pos_nxt = count_r;
            end
          end
        end
      end
      SEQ_SHL_INIT: begin
        rd_idx_nxt  = pos_r + CNT_W'(1);
        chk_vld_nxt = 1'b0;
      end
      SEQ_SHR_INIT: begin
        rd_idx_nxt  = count_r;
        chk_vld_nxt = 1'b0;
      end
      SEQ_SHR: begin
        if (rd_idx_r > pos_r) begin
          chk_idx_nxt = rd_m1[IDX_W-1:0];
          chk_vld_nxt = 1'b1;
          rd_idx_nxt  = rd_m1;
        end else begin
          chk_vld_nxt = 1'b0;
        end
      end
      default: begin
        chk_vld_nxt = chk_vld_r;
      end
    endcase

    case (cmd.cnt)
      CNT_HOLD:  count_nxt = count_r;
      CNT_INIT:  count_nxt = CNT_W'(1);
      CNT_CLEAR: count_nxt = (min_r <= max_r) ? CNT_W'(1) : CNT_W'(0);
      CNT_INC:   count_nxt = count_r + CNT_W'(1);
      CNT_DEC:   count_nxt = count_r - CNT_W'(1);
      default:   count_nxt = count_r;
    endcase

    if (cfg_valid && (cfg_index == CFG_MIN_HANDLE)) begin
      min_nxt = cfg_wdata;
    end
    if (cfg_valid && (cfg_index == CFG_MAX_HANDLE)) begin
      max_nxt = cfg_wdata;
    end

    if (cmd.res_load) begin
      out_status_nxt = cmd.res_status;
      if ((kind_r == KIND_ALLOC) && (cmd.res_status == ST_OK)) begin
        out_start_nxt = cur_lo_r;
        out_end_nxt   = last_ext[HND_W-1:0];
      end else begin
        out_start_nxt = '0;
        out_end_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r  <= '0;
      chk_vld_r <= 1'b0;
      hit_r     <= 1'b0;
      pos_r     <= '0;
      count_r   <= CNT_W'(1);
      min_r     <= RST_MIN_HANDLE;
      max_r     <= RST_MAX_HANDLE;
    end else begin
      rd_idx_r  <= rd_idx_nxt;
      chk_vld_r <= chk_vld_nxt;
      hit_r     <= hit_nxt;
      pos_r     <= pos_nxt;
      count_r   <= count_nxt;
      min_r     <= min_nxt;
      max_r     <= max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    need_r       <= need_nxt;
    rel_lo_r     <= rel_lo_nxt;
    rel_hi_r     <= rel_hi_nxt;
    chk_idx_r    <= chk_idx_nxt;
    cur_lo_r     <= cur_lo_nxt;
    cur_hi_r     <= cur_hi_nxt;
    prev_lo_r    <= prev_lo_nxt;
    prev_hi_r    <= prev_hi_nxt;
    out_status_r <= out_status_nxt;
    out_start_r  <= out_start_nxt;
    out_end_r    <= out_end_nxt;
  end

  assign out_status      = out_status_r;
  assign out_range_start = out_start_r;
  assign out_range_end   = out_end_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_FREE))
    else $error("free range count above list depth");

  a_inc_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cnt == CNT_INC) |-> (count_r < CNT_W'(MAX_FREE)))
    else $error("insert into a full free list");

  a_dec_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cnt == CNT_DEC) |-> (count_r != '0))
    else $error("remove from an empty free list");

endmodule

// ===== rtl/hra_ctrl.sv =====
// ----------------------------------------------------------------------------
// hra_ctrl
// Controller: sequences walk, update and shift of the free list per item
// and owns the input and result handshakes.
// ----------------------------------------------------------------------------
module hra_ctrl
  import hra_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_kind,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output dp_cmd_t    cmd,
  input  dp_sts_t    sts
);

  state_t  state_r, state_nxt;
  status_t status_r, status_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    in_acc;
  logic    can_load;
  logic    rel_act;
  kind_t   in_kind_e;

  assign in_kind_e = kind_t'(in_kind);
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign can_load  = !out_valid_r || !out_stall;
  assign rel_act   = !sts.rev && !sts.overlap;
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          if ((in_kind_e == KIND_ALLOC) || (in_kind_e == KIND_RELEASE)) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_DECIDE;
          end
        end
      end
      S_SCAN: begin
        if (sts.scan_hit || sts.scan_end) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_OUT;
        case (sts.kind)
          KIND_ALLOC: begin
            if (sts.hit && !sts.shrink) begin
              state_nxt = S_SHL;
            end
          end
          KIND_RELEASE: begin
            if (rel_act && sts.join_prev && sts.join_next) begin
              state_nxt = S_SHL;
            end else if (rel_act && !sts.join_prev && !sts.join_next && !sts.full) begin
              state_nxt = S_SHR;
            end
          end
          default: begin
            state_nxt = S_OUT;
          end
        endcase
      end
      S_SHL: begin
        if (sts.shl_done) begin
          state_nxt = S_OUT;
        end
      end
      S_SHR: begin
        if (sts.shr_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (can_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd.load_in    = 1'b0;
    cmd.seq        = SEQ_NONE;
    cmd.wr         = WR_NONE;
    cmd.cnt        = CNT_HOLD;
    cmd.res_load   = 1'b0;
    cmd.res_status = status_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    case (state_r)
      S_INIT: begin
        cmd.wr  = WR_INIT;
        cmd.cnt = CNT_INIT;
      end
      S_IDLE: begin
        if (in_acc) begin
          cmd.load_in = 1'b1;
          cmd.seq     = SEQ_SCAN_INIT;
        end
      end
      S_SCAN: begin
        cmd.seq = SEQ_SCAN;
      end
      S_DECIDE: begin
        status_nxt = ST_OK;
        case (sts.kind)
          KIND_ALLOC: begin
            if (!sts.hit) begin
              status_nxt = ST_NO_SPACE;
            end else if (sts.shrink) begin
              cmd.wr = WR_SHRINK;
            end else begin
              cmd.seq = SEQ_SHL_INIT;
            end
          end
          KIND_RELEASE: begin
            if (rel_act) begin
              if (sts.join_prev && sts.join_next) begin
                cmd.wr  = WR_MERGE_BOTH;
                cmd.seq = SEQ_SHL_INIT;
              end else if (sts.join_prev) begin
                cmd.wr = WR_PREV_EXT;
              end else if (sts.join_next) begin
                cmd.wr = WR_NEXT_EXT;
              end else if (sts.full) begin
                status_nxt = ST_LIST_FULL;
              end else begin
                cmd.seq = SEQ_SHR_INIT;
              end
            end
          end
          KIND_CLEAR: begin
            if (sts.bounds_ok) begin
              cmd.wr = WR_CLEAR;
            end
            cmd.cnt = CNT_CLEAR;
          end
          default: begin
            status_nxt = ST_OK;
          end
        endcase
      end
      S_SHL: begin
        cmd.seq = SEQ_SHL;
        if (sts.shl_done) begin
          cmd.cnt = CNT_DEC;
        end
      end
      S_SHR: begin
        cmd.seq = SEQ_SHR;
        if (sts.shr_done) begin
          cmd.wr  = WR_INSERT;
          cmd.cnt = CNT_INC;
        end
      end
      S_OUT: begin
        if (can_load) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        cmd.seq = SEQ_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      status_r    <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_wait_result_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && out_stall) |=> (state_r == S_OUT))
    else $error("result overwritten while previous item still waits");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("controller idle right after accepting an item");

endmodule

// ===== rtl/handle_range_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// handle_range_allocator_unit
// First-fit handle range allocator over a sorted, coalescing free list.
// ----------------------------------------------------------------------------
// One item is worked on at a time. With n free ranges in the list, an
// allocate or release walks the list in the free list RAM at one entry per
// cycle until it finds its place, then passes through a decide state. A
// removal or insertion then shifts the entries behind that place one entry
// per cycle. The item is taken in the idle state and its result is loaded
// in the output state; a clear or an unused kind goes from the idle state
// straight to decide and output. The free list RAM has a single read port.
// A new item is taken while the previous result still waits in the output
// register. The next result is held back until that one has gone. After
// reset the block writes the initial range in its init state before it
// takes the first item. Register 0 is min_handle, register 1 is max_handle;
// both take effect on clear only.
// ----------------------------------------------------------------------------
module handle_range_allocator_unit
  import hra_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_kind,
  input  logic [15:0]          in_include_count,
  input  logic [14:0]          in_char_count,
  input  logic [15:0]          in_desc_count,
  input  logic [15:0]          in_release_start,
  input  logic [15:0]          in_release_end,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_status,
  output logic [15:0]          out_range_start,
  output logic [15:0]          out_range_end,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  hra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  hra_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_kind         (in_kind),
    .in_include_count(in_include_count),
    .in_char_count   (in_char_count),
    .in_desc_count   (in_desc_count),
    .in_release_start(in_release_start),
    .in_release_end  (in_release_end),
    .cfg_valid       (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_status      (out_status),
    .out_range_start (out_range_start),
    .out_range_end   (out_range_end)
  );

endmodule
